### hw/rtl/stp_pkg.sv
package stp_pkg;

  localparam int CoordBits = 10;
  localparam int OutBits   = CoordBits + 1;
  localparam int StepBits  = 16;
  localparam int TrigBits  = 16;
  localparam int ColorBits = 24;
  localparam int PhaseBitsDefault = 16;

  // Widths of the rotation datapath.
  localparam int RsW = CoordBits + TrigBits + 1;  // radius times Q15
  localparam int DW  = 48;                         // Q30 coordinates
  localparam int PW  = 64;                         // rotation products

  // Taylor coefficients of sin(pi/2 * x), Q30.
  localparam logic [31:0] K1 = 32'd1686629713;
  localparam logic [31:0] K3 = 32'd693598669;
  localparam logic [31:0] K5 = 32'd85569306;
  localparam logic [31:0] K7 = 32'd5026995;
  localparam logic [31:0] K9 = 32'd172272;

  typedef enum logic [2:0] {
    REG_RADIUS      = 3'd0,
    REG_COLUMN_STEP = 3'd1,
    REG_ROW_STEP    = 3'd2,
    REG_COS_TILT_X  = 3'd3,
    REG_SIN_TILT_X  = 3'd4,
    REG_COS_TILT_Y  = 3'd5,
    REG_SIN_TILT_Y  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [CoordBits-1:0] column;
    logic [CoordBits-1:0] row;
    logic [ColorBits-1:0] texel_color;
  } texel_t;

  typedef struct packed {
    logic [OutBits-1:0]   target_x;
    logic [OutBits-1:0]   target_y;
    logic [ColorBits-1:0] pixel_color;
  } pixel_t;

endpackage

### hw/rtl/stp_sine.sv
// Seven-stage Q1.15 sine of a 16-bit phase: the Horner multiplies sit in stages two to five.
module stp_sine (
  input  logic                clk,
  input  logic                en,
  input  logic [15:0]         phase,
  output logic signed [15:0]  sine
);
  import stp_pkg::*;

  logic [14:0] x_in;
  logic [14:0] x_r    [1:5];
  logic [1:0]  quad_r [1:6];
  logic [15:0] x2_r   [1:4];
  logic [31:0] t_r    [2:5];
  logic [32:0] s_r;
  logic [18:0] q_full;
  logic [15:0] q_clip;
  logic signed [15:0] sine_r;

  always_comb begin
    x_in = {1'b0, phase[13:0]};
    if (phase[14]) begin
      x_in = 15'h4000 - {1'b0, phase[13:0]};
    end
  end

  function automatic logic [31:0] horner(input logic [31:0] k, input logic [15:0] x2,
                                         input logic [31:0] t);
    logic [47:0] prod;
    begin
      prod = 48'(x2) * 48'(t);
      horner = k - prod[45:14];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[1]    <= x_in;
      quad_r[1] <= phase[15:14];
      x2_r[1]   <= 16'((30'(x_in) * 30'(x_in)) >> 14);
      for (int i = 2; i <= 5; i++) begin
        x_r[i] <= x_r[i-1];
      end
      for (int i = 2; i <= 6; i++) begin
        quad_r[i] <= quad_r[i-1];
      end
      for (int i = 2; i <= 4; i++) begin
        x2_r[i] <= x2_r[i-1];
      end
      t_r[2] <= horner(K7, x2_r[1], K9);
      t_r[3] <= horner(K5, x2_r[2], t_r[2]);
      t_r[4] <= horner(K3, x2_r[3], t_r[3]);
      t_r[5] <= horner(K1, x2_r[4], t_r[4]);
      s_r    <= 33'((47'(x_r[5]) * 47'(t_r[5])) >> 14);
      sine_r <= quad_r[6][1] ? -$signed(q_clip) : $signed(q_clip);
    end
  end

  always_comb begin
    q_full = 19'((34'(s_r) + 34'd16384) >> 15);
    q_clip = (q_full > 19'd32767) ? 16'd32767 : q_full[15:0];
  end

  assign sine = sine_r;

endmodule

### hw/rtl/sphere_texture_projector.sv
// Channel   Dir  Handshake             Payload
// in_       in   in_valid / in_ready   stp_pkg::texel_t (column, row, texel_color)
// out_      out  out_valid / out_ready stp_pkg::pixel_t (target_x, target_y, pixel_color)
// cfg_      in   cfg_we                cfg_index, cfg_wdata
//
// One texel enters per clock while the output is not stalled. A transaction's
// result passes through the phase stage, which captures it at the edge that
// accepts it, then seven sine stages, six rotation stages and the output register.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults. When the output register holds a result that is not
// taken, the whole pipeline freezes; bubbles never block intake.
module sphere_texture_projector #(
  parameter int PHASE_BITS = stp_pkg::PhaseBitsDefault
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  stp_pkg::texel_t          in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output stp_pkg::pixel_t          out_data,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [15:0]              cfg_wdata
);
  import stp_pkg::*;

  localparam int NStage = 14;
  localparam int ShR = (PHASE_BITS > 16) ? PHASE_BITS - 16 : 0;
  localparam int ShL = (PHASE_BITS < 16) ? 16 - PHASE_BITS : 0;
  localparam logic [OutBits-1:0] OutMax = {OutBits{1'b1}};

  // Configuration registers.
  logic [CoordBits-1:0]       radius_r;
  logic [StepBits-1:0]        column_step_r, row_step_r;
  logic signed [TrigBits-1:0] cos_x_r, sin_x_r, cos_y_r, sin_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= CoordBits'(50);
      column_step_r <= 16'd128;
      row_step_r    <= 16'd64;
      cos_x_r       <= 16'sd2318;
      sin_x_r       <= 16'sd32685;
      cos_y_r       <= -16'sd26251;
      sin_y_r       <= -16'sd19611;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RADIUS:      radius_r      <= cfg_wdata[CoordBits-1:0];
        REG_COLUMN_STEP: column_step_r <= cfg_wdata;
        REG_ROW_STEP:    row_step_r    <= cfg_wdata;
        REG_COS_TILT_X:  cos_x_r       <= $signed(cfg_wdata);
        REG_SIN_TILT_X:  sin_x_r       <= $signed(cfg_wdata);
        REG_COS_TILT_Y:  cos_y_r       <= $signed(cfg_wdata);
        REG_SIN_TILT_Y:  sin_y_r       <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Global advance: everything moves unless a finished result is stuck.
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  logic                 v_r     [0:NStage-1];
  logic [ColorBits-1:0] color_r [0:NStage-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NStage; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < NStage; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      color_r[0] <= in_data.texel_color;
      for (int i = 1; i < NStage; i++) color_r[i] <= color_r[i-1];
    end
  end

  // Stage 0: longitude and colatitude phases.
  logic [PHASE_BITS-1:0] theta_r, phi_r;
  logic [31:0] col_prod, row_prod;
  assign col_prod = 32'(in_data.column) * 32'(column_step_r);
  assign row_prod = 32'(in_data.row) * 32'(row_step_r);

  always_ff @(posedge clk) begin
    if (en) begin
      theta_r <= PHASE_BITS'(32'd0 - col_prod);
      phi_r   <= PHASE_BITS'(row_prod);
    end
  end

  // Reduce a phase to 16 bits of a turn.
  logic [15:0] theta16, phi16;
  assign theta16 = 16'((32'(theta_r) >> ShR) << ShL);
  assign phi16   = 16'((32'(phi_r) >> ShR) << ShL);

  // Stages 1..7: four sine units, cosine taken as sine a quarter turn on.
  logic signed [15:0] st, ct, sp, cp;
  stp_sine u_sin_theta (.clk, .en, .phase(theta16),            .sine(st));
  stp_sine u_cos_theta (.clk, .en, .phase(theta16 + 16'h4000), .sine(ct));
  stp_sine u_sin_phi   (.clk, .en, .phase(phi16),              .sine(sp));
  stp_sine u_cos_phi   (.clk, .en, .phase(phi16 + 16'h4000),   .sine(cp));

  // Stages 8..13: sphere point and the two rotations.
  logic signed [CoordBits:0] r_s;
  assign r_s = $signed({1'b0, radius_r});

  logic signed [RsW-1:0] rsp_r, rcp_r;
  logic signed [15:0]    ct8_r, st8_r;
  logic signed [DW-1:0]  x9_r, y9_r, zs9_r, zc9_r;
  logic signed [DW-1:0]  x10_r, zs10_r, zc10_r;
  logic signed [PW-1:0]  ycx_r, ysn_r;
  logic signed [DW-1:0]  x11_r, y1_r, z1_r;
  logic signed [PW-1:0]  xcy_r, xsn_r, z1cy_r, z1sn_r;
  logic signed [DW-1:0]  y12_r, x1_r, y13_r, z2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 8.
      rsp_r <= RsW'(r_s * sp);
      rcp_r <= RsW'(r_s * cp);
      ct8_r <= ct;
      st8_r <= st;
      // Stage 9: x and y in Q30; z times each Q15 X-tilt term, also in Q30.
      x9_r  <= DW'(rsp_r * ct8_r);
      y9_r  <= DW'(rsp_r * st8_r);
      zs9_r <= DW'(rcp_r * sin_x_r);
      zc9_r <= DW'(rcp_r * cos_x_r);
      // Stage 10.
      ycx_r  <= PW'(y9_r * cos_x_r);
      ysn_r  <= PW'(y9_r * sin_x_r);
      x10_r  <= x9_r;
      zs10_r <= zs9_r;
      zc10_r <= zc9_r;
      // Stage 11: rotation about X, floored back to Q30.
      y1_r  <= DW'((ycx_r - (PW'(zs10_r) <<< 15)) >>> 15);
      z1_r  <= DW'((ysn_r + (PW'(zc10_r) <<< 15)) >>> 15);
      x11_r <= x10_r;
      // Stage 12.
      xcy_r  <= PW'(x11_r * cos_y_r);
      xsn_r  <= PW'(x11_r * sin_y_r);
      z1cy_r <= PW'(z1_r * cos_y_r);
      z1sn_r <= PW'(z1_r * sin_y_r);
      y12_r  <= y1_r;
      // Stage 13: rotation about Y.
      x1_r  <= DW'((xcy_r - z1sn_r) >>> 15);
      z2_r  <= DW'((xsn_r + z1cy_r) >>> 15);
      y13_r <= y12_r;
    end
  end

  // Truncate Q30 toward zero, add the radius and saturate to the output range.
  function automatic logic [OutBits-1:0] place(input logic signed [DW-1:0] v,
                                               input logic [CoordBits-1:0] r);
    logic signed [DW-1:0] mag;
    logic signed [DW-1:0] whole;
    logic signed [DW-1:0] sum;
    begin
      mag   = (v < 0) ? -v : v;
      whole = mag >>> 30;
      if (v < 0) whole = -whole;
      sum = whole + DW'(r);
      if (sum < 0) place = '0;
      else if (sum > DW'(OutMax)) place = OutMax;
      else place = sum[OutBits-1:0];
    end
  endfunction

  pixel_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[NStage-1] && (z2_r > 0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.target_x    <= place(x1_r, radius_r);
      out_data_r.target_y    <= place(y13_r, radius_r);
      out_data_r.pixel_color <= color_r[NStage-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

// Testbench for the sphere texture projector.
//
// Every texel transaction that the block accepts is handed to a scoreboard.
// The scoreboard keeps its own copy of the configuration registers and works
// out, in plain integer arithmetic, where the texel lands on the rotated
// sphere. If the rotated depth is positive it queues the pixel it expects.
// Each pixel transaction on the output is compared field by field with the
// oldest queued pixel.
module testbench;
  import stp_pkg::*;

  localparam int PhaseBits = PhaseBitsDefault;
  localparam longint OutMax = (longint'(1) << OutBits) - 1;
  // The block decodes only indexes 0 to 6, so writes to this one must be ignored.
  localparam logic [2:0] UnusedIndex = 3'd7;
  // This margin covers the pipeline depth with room to spare.
  localparam int SettleCycles = 40;
  localparam int WatchdogLimit = 5000;
  localparam int RandomPhases = 12;
  localparam int ItemsPerPhase = 95;

  // Holds a copy of the block's registers and the pixels still owed by the block.
  class projector_scoreboard;
    pixel_t owed_q[$];
    int unsigned errors;
    int unsigned matched;
    logic [CoordBits-1:0] radius;
    logic [StepBits-1:0] column_step;
    logic [StepBits-1:0] row_step;
    logic signed [TrigBits-1:0] cos_x, sin_x, cos_y, sin_y;

    function new();
      radius = 10'd50;
      column_step = 16'd128;
      row_step = 16'd64;
      cos_x = 16'sd2318;
      sin_x = 16'sd32685;
      cos_y = -16'sd26251;
      sin_y = -16'sd19611;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] value);
      case (idx)
        REG_RADIUS:      radius = value[CoordBits-1:0];
        REG_COLUMN_STEP: column_step = value;
        REG_ROW_STEP:    row_step = value;
        REG_COS_TILT_X:  cos_x = value;
        REG_SIN_TILT_X:  sin_x = value;
        REG_COS_TILT_Y:  cos_y = value;
        REG_SIN_TILT_Y:  sin_y = value;
        default: ;
      endcase
    endfunction

    // Scales a phase of PhaseBits bits to a 16-bit turn fraction.
    function logic [15:0] to_turn16(int unsigned ph);
      int unsigned scaled;
      if (PhaseBits > 16) scaled = ph >> (PhaseBits - 16);
      else scaled = ph << (16 - PhaseBits);
      return scaled[15:0];
    endfunction

    // Q1.15 sine by quarter-wave folding and a Horner polynomial in Q30.
    function longint sine_q15(logic [15:0] p);
      longint unsigned x, x2, t, s, q;
      logic [1:0] quad;
      quad = p[15:14];
      x = p[13:0];
      if (quad[0]) x = 64'd16384 - x;
      x2 = (x * x) >> 14;
      t = K9;
      t = K7 - ((x2 * t) >> 14);
      t = K5 - ((x2 * t) >> 14);
      t = K3 - ((x2 * t) >> 14);
      t = K1 - ((x2 * t) >> 14);
      s = (x * t) >> 14;
      q = (s + 64'd16384) >> 15;
      if (q > 64'd32767) q = 32767;
      return quad[1] ? -longint'(q) : longint'(q);
    endfunction

    function longint toward_zero_q30(longint v);
      return (v >= 0) ? (v >>> 30) : -((-v) >>> 30);
    endfunction

    function logic [OutBits-1:0] pixel_range(longint v);
      if (v < 0) return '0;
      if (v > OutMax) return OutMax[OutBits-1:0];
      return v[OutBits-1:0];
    endfunction

    function void note_texel(texel_t t);
      int unsigned mask, theta, phi;
      longint r, st, ct, sp, cp, x, y, z, y1, z1, x1, z2;
      pixel_t px;
      mask = (PhaseBits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << PhaseBits) - 1);
      theta = (32'd0 - t.column * column_step) & mask;
      phi = (t.row * row_step) & mask;
      r = radius;
      st = sine_q15(to_turn16(theta));
      ct = sine_q15(to_turn16(theta) + 16'h4000);
      sp = sine_q15(to_turn16(phi));
      cp = sine_q15(to_turn16(phi) + 16'h4000);
      x = r * sp * ct;
      y = r * sp * st;
      z = r * cp * 32768;
      // Tilt about X first, then about Y; each product is floored back to Q30.
      y1 = (y * cos_x - z * sin_x) >>> 15;
      z1 = (y * sin_x + z * cos_x) >>> 15;
      x1 = (x * cos_y - z1 * sin_y) >>> 15;
      z2 = (x * sin_y + z1 * cos_y) >>> 15;
      if (z2 > 0) begin
        px.target_x = pixel_range(toward_zero_q30(x1) + r);
        px.target_y = pixel_range(toward_zero_q30(y1) + r);
        px.pixel_color = t.texel_color;
        owed_q.push_back(px);
      end
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %p", got));
        return;
      end
      want = owed_q.pop_front();
      if (got.target_x !== want.target_x)
        report_mismatch($sformatf("target_x %0d, want %0d", got.target_x, want.target_x));
      if (got.target_y !== want.target_y)
        report_mismatch($sformatf("target_y %0d, want %0d", got.target_y, want.target_y));
      if (got.pixel_color !== want.pixel_color)
        report_mismatch($sformatf("pixel_color %h, want %h", got.pixel_color,
                                  want.pixel_color));
      matched++;
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  texel_t in_data;
  logic out_valid;
  logic out_ready;
  pixel_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_wdata;

  projector_scoreboard sb;
  // While set, neither side idles, so the pipeline runs at full rate.
  logic steady;
  int unsigned texels_sent;
  int unsigned idle_cycles;

  sphere_texture_projector uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // The receiver stalls with a probability of 14 percent, except in the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 14);
  end

  // Values read right at the edge are the ones from before it, so each
  // transaction is seen exactly once, whatever the order of processes.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_pixel(out_data);
  end

  // The run is declared hung if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Watchdog expired with %0d pixels outstanding", sb.owed_q.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one texel, with an occasional random gap before it, and waits
  // until the block takes it.
  task send_texel(texel_t t);
    if (!steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_texel(t);
    texels_sent++;
  endtask

  task send_random_texel();
    texel_t t;
    t.column = 10'($urandom);
    t.row = 10'($urandom);
    t.texel_color = 24'($urandom);
    send_texel(t);
  endtask

  // Stops the sender and waits until every owed pixel has come out and
  // the pipeline has had time to empty, so registers can be changed safely.
  task drain();
    in_valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task load_setup(logic [9:0] rad, logic [15:0] cstep, logic [15:0] rstep,
                  logic [15:0] cx, logic [15:0] sx, logic [15:0] cy, logic [15:0] sy);
    write_reg(REG_RADIUS, {6'd0, rad});
    write_reg(REG_COLUMN_STEP, cstep);
    write_reg(REG_ROW_STEP, rstep);
    write_reg(REG_COS_TILT_X, cx);
    write_reg(REG_SIN_TILT_X, sx);
    write_reg(REG_COS_TILT_Y, cy);
    write_reg(REG_SIN_TILT_Y, sy);
  endtask

  // Most random setups use true rotations, the rest arbitrary register
  // pairs that push coordinates out of range.
  task random_setup();
    logic [15:0] ax, ay, cx, sx, cy, sy;
    logic [9:0] rad;
    ax = 16'($urandom);
    ay = 16'($urandom);
    cx = 16'(sb.sine_q15(ax + 16'h4000));
    sx = 16'(sb.sine_q15(ax));
    cy = 16'(sb.sine_q15(ay + 16'h4000));
    sy = 16'(sb.sine_q15(ay));
    if ($urandom_range(3) == 0) begin
      cx = 16'($urandom);
      sx = 16'($urandom);
      cy = 16'($urandom);
      sy = 16'($urandom);
    end
    rad = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(20, 400));
    load_setup(rad, 16'($urandom), ($urandom_range(1) == 0) ? 16'($urandom) :
               16'($urandom_range(0, 128)), cx, sx, cy, sy);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    out_ready = 1'b0;
    steady = 1'b0;
    idle_cycles = 0;
    texels_sent = 0;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed texels under the reset settings: corners of the texture,
    // the pole rows and the extreme colours.
    send_texel('{column: 10'd0, row: 10'd0, texel_color: 24'h000000});
    send_texel('{column: 10'd1023, row: 10'd1023, texel_color: 24'hFFFFFF});
    send_texel('{column: 10'd0, row: 10'd1023, texel_color: 24'hA5A5A5});
    send_texel('{column: 10'd1023, row: 10'd0, texel_color: 24'h5A5A5A});
    send_texel('{column: 10'd512, row: 10'd512, texel_color: 24'hFF0000});
    send_texel('{column: 10'd256, row: 10'd256, texel_color: 24'h00FF00});
    send_texel('{column: 10'd128, row: 10'd400, texel_color: 24'h0000FF});
    send_texel('{column: 10'd300, row: 10'd700, texel_color: 24'h123456});
    drain();

    // Untilted sphere at the largest radius.
    load_setup(10'd1023, 16'd64, 16'd64, 16'sd32767, 16'sd0, 16'sd32767, 16'sd0);
    send_texel('{column: 10'd0, row: 10'd256, texel_color: 24'hFFFFFF});
    send_texel('{column: 10'd512, row: 10'd256, texel_color: 24'h000001});
    send_texel('{column: 10'd256, row: 10'd128, texel_color: 24'h800000});
    send_texel('{column: 10'd768, row: 10'd384, texel_color: 24'h00007F});
    // A write to an index the block does not decode must change nothing.
    drain();
    write_reg(UnusedIndex, 16'hFFFF);
    send_texel('{column: 10'd100, row: 10'd200, texel_color: 24'h0F0F0F});

    // Zero radius: every point lies at the centre, so nothing comes out.
    drain();
    write_reg(REG_RADIUS, 16'd0);
    send_texel('{column: 10'd5, row: 10'd9, texel_color: 24'hABCDEF});
    send_texel('{column: 10'd1023, row: 10'd511, texel_color: 24'h010203});

    // Largest steps wrap the phases, and the most negative tilt values are not
    // of unit length, so coordinates saturate at both ends.
    drain();
    load_setup(10'd1023, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
    for (int i = 0; i < 8; i++) send_random_texel();
    drain();
    load_setup(10'd1, 16'd0, 16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_texel('{column: 10'd1023, row: 10'd1023, texel_color: 24'hFFFFFF});
    drain();

    // Random phases, each under its own settings. One of them runs with
    // no idling on either side, so the pipeline is kept full.
    for (int p = 0; p < RandomPhases; p++) begin
      random_setup();
      steady = (p == 4);
      for (int i = 0; i < ItemsPerPhase; i++) begin
        send_random_texel();
        // Halfway through phase 7 the sender holds off until all is delivered.
        if (p == 7 && i == ItemsPerPhase / 2) drain();
      end
      drain();
    end
    steady = 1'b0;

    $display("Sent %0d texels over %0d register setups; %0d pixels checked.",
             texels_sent, RandomPhases + 5, sb.matched);
    $display("Covered pole rows, phase wrap, zero radius, saturation and backpressure.");
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

### sim.f
hw/rtl/stp_pkg.sv
hw/rtl/stp_sine.sv
hw/rtl/sphere_texture_projector.sv
verif/testbench.sv
